FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the sampler's back end.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rst, prop, msg)
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/zrs_pkg.sv
// ----------------------------------------------------------------------------
// Zipf rank sampler package
// Widths, command codes, generator constants and beat types.
// ----------------------------------------------------------------------------
package zrs_pkg;

   localparam int MAX_RANKS   = 4096;
   localparam int RANK_AW     = $clog2(MAX_RANKS);
   localparam int CNT_W       = RANK_AW + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_SEED  = 2'd1;
   localparam logic [1:0] MODE_DRAW  = 2'd2;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SEED  = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   localparam logic [30:0] PM_M = 31'h7FFF_FFFF;
   localparam logic [14:0] PM_A = 15'd16807;
   localparam logic [30:0] SEED_FIX = 31'd1;
   localparam logic [12:0] NUM_RANKS_RESET = 13'd4096;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] rank_index;
      logic [30:0] value;
   } req_type;

   typedef struct packed {
      logic [12:0] rank;
      logic [30:0] uniform_draw;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] rank_index;
      logic [30:0] value;
   } cmd_type;

endpackage

FILE: rtl/zrs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module zrs_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/zrs_front.sv
// ----------------------------------------------------------------------------
// Sampler front end
// Accepts request beats, turns them into commands and queues them; beats of the unused mode are dropped.
// ----------------------------------------------------------------------------
module zrs_front
   import zrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output cmd_type cmd_data
);

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;
   cmd_type              cmd_new;
   logic                 keep;
   logic                 enq;
   logic                 deq;

   always_comb begin
      cmd_new.rank_index = req_data.rank_index;
      cmd_new.value      = req_data.value;
      cmd_new.op         = OP_WRITE;
      keep               = 1'b1;
      unique case (req_data.mode)
         MODE_WRITE: begin
            cmd_new.op = OP_WRITE;
         end
         MODE_SEED: begin
            cmd_new.op = OP_SEED;
            if (req_data.value == '0 || req_data.value == PM_M) begin
               cmd_new.value = SEED_FIX;
            end
         end
         MODE_DRAW: begin
            cmd_new.op = OP_DRAW;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign enq       = push && !full && keep;
   assign cmd_valid = (count_ff != '0);
   assign deq       = cmd_take && cmd_valid;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: rtl/zrs_back.sv
// ----------------------------------------------------------------------------
// Sampler back end
// Runs weight writes, seeding and draws: generator step, then a walk of the
// weight memory one rank per cycle, with a one-beat result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zrs_back
   import zrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd_data,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FOLD = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   logic [2:0]         state_ff, state_in;
   logic [30:0]        rng_ff, rng_in;
   logic [45:0]        prod_ff, prod_in;
   logic [31:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [RANK_AW-1:0] pend_idx_ff, pend_idx_in;
   logic [12:0]        rank_ff, rank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [12:0]        num_ranks_ff, num_ranks_in;

   logic [CNT_W-1:0]   limit;
   logic [31:0]        fold_sum;
   logic [30:0]        fold_res;
   logic [32:0]        add_wide;
   logic [31:0]        sum_sat;
   logic [CNT_W-1:0]   pend_next;
   logic               issue_now;
   logic               finish;
   logic               ram_we;
   logic [30:0]        ram_rd_data;

   assign limit = (num_ranks_ff > 13'(MAX_RANKS)) ? CNT_W'(MAX_RANKS) : CNT_W'(num_ranks_ff);

   assign fold_sum = {17'd0, prod_ff[45:31]} + {1'b0, prod_ff[30:0]};
   assign fold_res = (fold_sum >= {1'b0, PM_M}) ? 31'(fold_sum - {1'b0, PM_M})
                                                 : fold_sum[30:0];

   assign add_wide  = {1'b0, sum_ff} + {2'b00, ram_rd_data};
   assign sum_sat   = add_wide[32] ? 32'hFFFF_FFFF : add_wide[31:0];
   assign pend_next = CNT_W'(pend_idx_ff) + 1'b1;

   assign cmd_take = (state_ff == ST_IDLE);
   assign ram_we   = cmd_take && cmd_valid && (cmd_data.op == OP_WRITE)
                     && ({20'd0, cmd_data.rank_index} < 32'(MAX_RANKS));
   assign issue_now = (state_ff == ST_WALK) && (issue_ff < limit);

   always_comb begin
      state_in     = state_ff;
      rng_in       = rng_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      issue_in     = issue_ff;
      pend_idx_in  = pend_idx_ff;
      rank_in      = rank_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      finish       = 1'b0;
      num_ranks_in = csr_wr_en ? csr_wr_data : num_ranks_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.op == OP_SEED) begin
                  rng_in = cmd_data.value;
               end else if (cmd_data.op == OP_DRAW) begin
                  prod_in  = {15'd0, rng_ff} * {31'd0, PM_A};
                  state_in = ST_FOLD;
               end
            end
         end
         ST_FOLD: begin
            rng_in   = fold_res;
            sum_in   = '0;
            issue_in = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (pend_ff) begin
               sum_in = sum_sat;
               if (sum_sat >= {1'b0, rng_ff}) begin
                  rank_in = 13'(pend_next);
                  finish  = 1'b1;
               end else if (pend_next == limit) begin
                  rank_in = '0;
                  finish  = 1'b1;
               end
            end else if (!issue_now) begin
               rank_in = '0;
               finish  = 1'b1;
            end
            if (issue_now) begin
               issue_in    = issue_ff + 1'b1;
               pend_idx_in = issue_ff[RANK_AW-1:0];
            end
            if (finish) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || pop) begin
               rsp_in.rank         = rank_ff;
               rsp_in.uniform_draw = rng_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      pend_in = issue_now && !finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= SEED_FIX;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_ranks_ff <= NUM_RANKS_RESET;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         num_ranks_ff <= num_ranks_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      rank_ff     <= rank_in;
      rsp_ff      <= rsp_in;
   end

   zrs_ram #(
      .WIDTH(31),
      .DEPTH(MAX_RANKS)
   ) u_weights (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(cmd_data.rank_index[RANK_AW-1:0]),
      .wr_data(cmd_data.value),
      .rd_en  (issue_now),
      .rd_addr(issue_ff[RANK_AW-1:0]),
      .rd_data(ram_rd_data)
   );

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `AST_ALWAYS(a_rng_range, clock, reset, rng_ff != '0 && rng_ff != PM_M, "generator state left its range")
   `AST_IMPLY(a_pend_walk, clock, reset, pend_ff, state_ff == ST_WALK, "weight read pending outside walk")
   `AST_IMPLY(a_pend_limit, clock, reset, pend_ff, CNT_W'(pend_idx_ff) < limit, "walk read beyond rank count")
   `AST_IMPLY(a_done_rank, clock, reset, state_ff == ST_DONE, CNT_W'(rank_ff) <= limit, "drawn rank beyond rank count")

endmodule

FILE: rtl/zipf_rank_sampler_unit.sv
// ----------------------------------------------------------------------------
// Zipf rank sampler
// Draws Zipf ranks by inverse-transform sampling over host-loaded weights,
// driven by a minimal-standard multiplicative generator.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake         Beat
//   request   in         push / full       req_type: mode, rank_index, value
//   response  out        empty / pop       rsp_type: rank, uniform_draw
//   csr       in         csr_wr_en         num_ranks, 13 bits
//
// A weight write or seed is done in the back end's idle state; a draw steps
// the generator, then walks the ranks (at most num_ranks) one rank per cycle,
// a rate set by the single read port of the weight memory.
// Reset sets the seed to 1 and num_ranks to 4096; the weights are not cleared.
// A four-beat command queue lets requests enter while a draw is running, and
// a one-beat result register lets the next command start while a result waits.
// ----------------------------------------------------------------------------
module zipf_rank_sampler_unit
   import zrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   zrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd_take (cmd_take),
      .cmd_data (cmd_data)
   );

   zrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_take   (cmd_take),
      .cmd_data   (cmd_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/sv/zipf_rank_sampler_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zipf rank sampler checker
// Watches the request, result and csr ports of the sampler, keeps its own
// copy of the weight table, generator state and rank count, predicts the
// result beat of every accepted draw and compares each accepted result beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module zipf_rank_sampler_unit_checker
   import zrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  req_type     req_data,
   input  logic        empty,
   input  logic        pop,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam longint SCHRAGE_Q = 127773;
   localparam longint SCHRAGE_R = 2836;
   localparam longint SUM_CEILING = 64'h0000_0000_FFFF_FFFF;

   bit [30:0]   weight_table [MAX_RANKS];
   logic [30:0] seed_state;
   logic [12:0] num_ranks;
   rsp_type     pending_draws [$];

   function automatic logic [30:0] next_uniform(input logic [30:0] x);
      longint hi;
      longint lo;
      longint t;
      hi = longint'(x) / SCHRAGE_Q;
      lo = longint'(x) % SCHRAGE_Q;
      t = longint'(PM_A) * lo - SCHRAGE_R * hi;
      if (t <= 0) begin
         t = t + longint'(PM_M);
      end
      return t[30:0];
   endfunction

   function automatic rsp_type predict_draw();
      rsp_type result;
      longint  run_sum;
      int      span;
      seed_state = next_uniform(seed_state);
      span = (num_ranks > MAX_RANKS) ? MAX_RANKS : int'(num_ranks);
      result.rank = '0;
      result.uniform_draw = seed_state;
      run_sum = 0;
      for (int i = 0; i < span; i++) begin
         run_sum = run_sum + longint'(weight_table[i]);
         if (run_sum > SUM_CEILING) begin
            run_sum = SUM_CEILING;
         end
         if (run_sum >= longint'(seed_state)) begin
            result.rank = 13'(i + 1);
            break;
         end
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         seed_state = SEED_FIX;
         num_ranks = NUM_RANKS_RESET;
         pending_draws.delete();
      end else begin
         if (pop && !empty) begin
            if (pending_draws.size() == 0) begin
               report_mismatch("result beat with no draw pending", 32'(rsp_data.rank), '0);
            end else begin
               want = pending_draws.pop_front();
               if (rsp_data.rank !== want.rank) begin
                  report_mismatch("rank", 32'(rsp_data.rank), 32'(want.rank));
               end
               if (rsp_data.uniform_draw !== want.uniform_draw) begin
                  report_mismatch("uniform_draw", 32'(rsp_data.uniform_draw),
                                  32'(want.uniform_draw));
               end
            end
         end
         if (push && !full) begin
            case (req_data.mode)
               MODE_WRITE: begin
                  weight_table[req_data.rank_index] = req_data.value;
               end
               MODE_SEED: begin
                  if (req_data.value == '0 || req_data.value == PM_M) begin
                     seed_state = SEED_FIX;
                  end else begin
                     seed_state = req_data.value;
                  end
               end
               MODE_DRAW: begin
                  pending_draws.push_back(predict_draw());
               end
               default: begin
               end
            endcase
         end
         if (csr_wr_en) begin
            num_ranks = csr_wr_data;
         end
      end
      pending_count = pending_draws.size();
   end

endmodule

FILE: tb/sv/zipf_rank_sampler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zipf rank sampler testbench
// Drives the sampler with a directed sequence of weight writes, seeds and
// draws, a short table prefix under the largest rank counts, and then random
// beats under several idle and stall patterns, including a long result
// hold-off that backs up the request queue. The checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module zipf_rank_sampler_unit_tb
   import zrs_pkg::*;
();

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 32;
   localparam int END_CYCLES    = 4200;
   localparam int HOLD_CYCLES   = 500;
   localparam int PHASE_ITEMS   = 18;
   localparam int PREFIX_RANKS  = 8;
   localparam logic [30:0] MAX_VALUE = 31'h7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int active_ranks = MAX_RANKS;
   bit hold_go = 1'b0;

   zipf_rank_sampler_unit dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   zipf_rank_sampler_unit_checker rank_check (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // The receiver counts its own long hold-off once the stimulus asks for it.
   initial begin
      bit hold_served;
      hold_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_served) begin
            hold_served = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [1:0] mode, input logic [11:0] index,
                            input logic [30:0] value);
      req_type beat;
      beat.mode = mode;
      beat.rank_index = index;
      beat.value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_num_ranks(input logic [12:0] count);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      active_ranks = (count > MAX_RANKS) ? MAX_RANKS : int'(count);
   endtask

   // Weights are scaled so that the running sum over the active ranks lands
   // near the full generator range and draws spread over the table.
   task automatic load_weights(input int count);
      longint weight;
      longint mean;
      mean = longint'(MAX_VALUE) / count;
      for (int i = 0; i < count; i++) begin
         weight = longint'($urandom_range(0, 32'(2 * mean)));
         if (weight > longint'(MAX_VALUE)) begin
            weight = longint'(MAX_VALUE);
         end
         send_beat(MODE_WRITE, 12'(i), weight[30:0]);
      end
   endtask

   task automatic send_random_items(input int count);
      int          pick;
      logic [1:0]  mode;
      logic [11:0] index;
      logic [31:0] value;
      repeat (count) begin
         pick = $urandom_range(99);
         index = 12'($urandom_range(MAX_RANKS - 1));
         value = $urandom();
         if (pick < 60) begin
            mode = MODE_DRAW;
         end else if (pick < 82) begin
            mode = MODE_WRITE;
            if ($urandom_range(1) == 1 && active_ranks > 0) begin
               index = 12'($urandom_range(active_ranks - 1));
            end
            value = value >> $urandom_range(0, 6);
         end else if (pick < 94) begin
            mode = MODE_SEED;
            case ($urandom_range(7))
               0: value = '0;
               1: value = 32'(MAX_VALUE);
               default: begin
               end
            endcase
         end else begin
            mode = MODE_UNUSED;
         end
         send_beat(mode, index, value[30:0]);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_num_ranks(13'd4);
      for (int i = 0; i < 4; i++) begin
         send_beat(MODE_WRITE, 12'(i), '0);
      end
      send_beat(MODE_DRAW, '0, '0);
      send_beat(MODE_SEED, '0, '0);
      send_beat(MODE_WRITE, 12'd0, 31'd16807);
      send_beat(MODE_DRAW, '0, '0);
      send_beat(MODE_SEED, '0, MAX_VALUE);
      send_beat(MODE_WRITE, 12'd0, 31'd16806);
      send_beat(MODE_WRITE, 12'd1, 31'd1);
      send_beat(MODE_DRAW, '0, '0);
      send_beat(MODE_UNUSED, 12'd0, MAX_VALUE);
      send_beat(MODE_SEED, '0, 31'd1);
      send_beat(MODE_DRAW, '0, '0);
      send_beat(MODE_SEED, '0, MAX_VALUE - 31'd1);
      send_beat(MODE_DRAW, '0, '0);
      send_beat(MODE_WRITE, 12'hFFF, MAX_VALUE);
      send_beat(MODE_WRITE, 12'd2, MAX_VALUE);
      send_beat(MODE_WRITE, 12'd3, MAX_VALUE);
      send_beat(MODE_DRAW, '0, '0);
      send_beat(MODE_WRITE, 12'd0, '0);
      send_beat(MODE_WRITE, 12'd1, '0);
      send_beat(MODE_DRAW, '0, '0);
      write_num_ranks(13'd0);
      send_beat(MODE_DRAW, '0, '0);
      write_num_ranks(13'd1);
      send_beat(MODE_DRAW, '0, '0);

      // The entry written just after the prefix alone covers any threshold, so the walk
      // never goes past the loaded entries.
      write_num_ranks(NUM_RANKS_RESET);
      load_weights(PREFIX_RANKS);
      send_beat(MODE_WRITE, 12'(PREFIX_RANKS), MAX_VALUE);
      repeat (3) send_beat(MODE_DRAW, '0, '0);
      write_num_ranks(13'h1FFF);
      repeat (2) send_beat(MODE_DRAW, '0, '0);
      write_num_ranks(13'd4097);
      send_beat(MODE_DRAW, '0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 77 : (phase == 3) ? 34 : 0;
         recv_stall_pct = (phase == 2) ? 77 : (phase == 3) ? 34 : 0;
         write_num_ranks(13'($urandom_range((phase == 0) ? 8 : 1, 12)));
         load_weights(active_ranks);
         if (phase == 0) begin
            hold_go = 1'b1;
         end
         send_random_items(PHASE_ITEMS);
         wait_idle();
      end

      repeat (END_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/zrs_pkg.sv
rtl/zrs_ram.sv
rtl/zrs_front.sv
rtl/zrs_back.sv
rtl/zipf_rank_sampler_unit.sv
tb/sv/zipf_rank_sampler_unit_checker.sv
tb/sv/zipf_rank_sampler_unit_tb.sv
